>>> hw/rtl/u8vd_pkg.sv
// Shared types, constants and helper functions of the UTF-8 validating decoder.
package u8vd_pkg;

    // Sizes of one decode step.
    localparam int MaxTok     = 4;
    localparam int HeldMax    = 3;
    localparam int QueueDepth = 2;
    localparam int QueueIdxW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    // Lead byte ranges.
    localparam logic [7:0] AsciiTop   = 8'h80;
    localparam logic [7:0] LeadTwoLo  = 8'hC2;
    localparam logic [7:0] LeadTwoHi  = 8'hDF;
    localparam logic [7:0] LeadThrLo  = 8'hE0;
    localparam logic [7:0] LeadThrHi  = 8'hEF;
    localparam logic [7:0] LeadFourLo = 8'hF0;
    localparam logic [7:0] LeadFourHi = 8'hF4;

    // Code point limits.
    localparam logic [20:0] ShortestTwo = 21'h000080;
    localparam logic [20:0] ShortestThr = 21'h000800;
    localparam logic [20:0] SuppBase    = 21'h010000;
    localparam logic [20:0] CodeMax     = 21'h10FFFF;
    localparam logic [20:0] SurrLo      = 21'h00D800;
    localparam logic [20:0] SurrHi      = 21'h00DFFF;

    // Surrogate pair construction.
    localparam logic [15:0] HighSurrBase = 16'hD800;
    localparam logic [15:0] LowSurrBase  = 16'hDC00;
    localparam logic [9:0]  TenBitMask   = 10'h3FF;
    localparam logic [5:0]  ContMask     = 6'h3F;

    // One decoded token: a code point or a raw byte.
    typedef struct packed {
        logic [20:0] code;
        logic        raw;
    } tok_t;

    // All tokens that one input byte causes.
    typedef struct packed {
        tok_t [MaxTok-1:0] tok;
        logic [2:0]        cnt;
    } bundle_t;

    // Sequence length that a lead byte announces; zero for a byte that cannot lead.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b < AsciiTop) begin
            len = 3'd1;
        end else if (b >= LeadTwoLo && b <= LeadTwoHi) begin
            len = 3'd2;
        end else if (b >= LeadThrLo && b <= LeadThrHi) begin
            len = 3'd3;
        end else if (b >= LeadFourLo && b <= LeadFourHi) begin
            len = 3'd4;
        end
        return len;
    endfunction

    // A continuation byte has the form 10xxxxxx.
    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

endpackage

>>> hw/rtl/u8vd_front.sv
// Front part: accepts text bytes, resolves sequences and emits token bundles.
module u8vd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                in_ready,
    input  logic                q_full,
    output logic                q_push,
    output u8vd_pkg::bundle_t   q_data
);

    logic [7:0] pend_bytes_reg [u8vd_pkg::HeldMax];
    logic [7:0] pend_bytes_next [u8vd_pkg::HeldMax];
    logic [1:0] pend_count_reg;
    logic [1:0] pend_count_next;
    logic [7:0] bytes_w [u8vd_pkg::MaxTok];
    logic       accept;
    u8vd_pkg::bundle_t bundle_w;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Line up the held bytes followed by the new byte.
    always_comb begin
        for (int m = 0; m < u8vd_pkg::MaxTok; m++) begin
            if (m < 32'(pend_count_reg)) begin
                bytes_w[m] = pend_bytes_reg[m];
            end else if (m == 32'(pend_count_reg)) begin
                bytes_w[m] = in_byte;
            end else begin
                bytes_w[m] = 8'h00;
            end
        end
    end

    // Scan the buffer from the start; each pass consumes at least one byte or holds the rest.
    always_comb begin : scan_proc
        logic [2:0]  pos;
        logic [2:0]  k;
        logic [2:0]  avail;
        logic [2:0]  len;
        logic [2:0]  lim;
        logic [2:0]  idx;
        logic        stop;
        logic        bad;
        logic [7:0]  lead;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [20:0] cp;
        logic [20:0] shortest;
        logic        emit;
        u8vd_pkg::tok_t tok;

        pos             = 3'd0;
        k               = {1'b0, pend_count_reg} + 3'd1;
        stop            = 1'b0;
        bundle_w        = '0;
        pend_count_next = 2'd0;
        for (int m = 0; m < u8vd_pkg::HeldMax; m++) begin
            pend_bytes_next[m] = 8'h00;
        end
        for (int it = 0; it < u8vd_pkg::MaxTok; it++) begin
            avail    = 3'd0;
            len      = 3'd0;
            lim      = 3'd0;
            idx      = 3'd0;
            bad      = 1'b0;
            lead     = 8'h00;
            b1       = 8'h00;
            b2       = 8'h00;
            b3       = 8'h00;
            cp       = 21'd0;
            shortest = 21'd0;
            emit     = 1'b0;
            tok      = '0;
            if (!stop && pos < k) begin
                lead  = bytes_w[pos[1:0]];
                len   = u8vd_pkg::lead_len(lead);
                avail = k - pos;
                lim   = (avail < len) ? avail : len;
                for (int j = 1; j < u8vd_pkg::MaxTok; j++) begin
                    idx = pos + 3'(j);
                    if (3'(j) < lim && !u8vd_pkg::is_cont(bytes_w[idx[1:0]])) begin
                        bad = 1'b1;
                    end
                end
                idx = pos + 3'd1;
                b1  = bytes_w[idx[1:0]];
                idx = pos + 3'd2;
                b2  = bytes_w[idx[1:0]];
                idx = pos + 3'd3;
                b3  = bytes_w[idx[1:0]];
                unique case (len)
                    3'd2: begin
                        cp       = {10'd0, lead[4:0], b1[5:0]};
                        shortest = u8vd_pkg::ShortestTwo;
                    end
                    3'd3: begin
                        cp       = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
                        shortest = u8vd_pkg::ShortestThr;
                    end
                    3'd4: begin
                        cp       = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
                        shortest = u8vd_pkg::SuppBase;
                    end
                    default: begin
                        cp       = {13'd0, lead};
                        shortest = 21'd0;
                    end
                endcase
                emit = 1'b1;
                if (len == 3'd0) begin
                    // Byte that cannot lead goes out raw.
                    tok = '{code: {13'd0, lead}, raw: 1'b1};
                    pos = pos + 3'd1;
                end else if (len == 3'd1) begin
                    tok = '{code: {13'd0, lead}, raw: 1'b0};
                    pos = pos + 3'd1;
                end else if (bad) begin
                    // Missing continuation: lead raw, rescan after it.
                    tok = '{code: {13'd0, lead}, raw: 1'b1};
                    pos = pos + 3'd1;
                end else if (avail < len) begin
                    if (in_last) begin
                        // Cut off by the end of the text.
                        tok = '{code: {13'd0, lead}, raw: 1'b1};
                        pos = pos + 3'd1;
                    end else begin
                        // Incomplete sequence is held for the next byte.
                        emit = 1'b0;
                        stop = 1'b1;
                        pend_count_next = avail[1:0];
                        for (int m = 0; m < u8vd_pkg::HeldMax; m++) begin
                            idx = pos + 3'(m);
                            if (3'(m) < avail) begin
                                pend_bytes_next[m] = bytes_w[idx[1:0]];
                            end
                        end
                    end
                end else if (cp < shortest || cp > u8vd_pkg::CodeMax ||
                             (cp >= u8vd_pkg::SurrLo && cp <= u8vd_pkg::SurrHi)) begin
                    // Over-long, surrogate or out of range.
                    tok = '{code: {13'd0, lead}, raw: 1'b1};
                    pos = pos + 3'd1;
                end else begin
                    tok = '{code: cp, raw: 1'b0};
                    pos = pos + len;
                end
                if (emit) begin
                    bundle_w.tok[bundle_w.cnt[1:0]] = tok;
                    bundle_w.cnt = bundle_w.cnt + 3'd1;
                end
            end
        end
    end

    assign q_push = accept && (bundle_w.cnt != 3'd0);
    assign q_data = bundle_w;

    // Held sequence state, updated on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_count_reg <= 2'd0;
            for (int m = 0; m < u8vd_pkg::HeldMax; m++) begin
                pend_bytes_reg[m] <= 8'h00;
            end
        end else if (accept) begin
            pend_count_reg <= pend_count_next;
            for (int m = 0; m < u8vd_pkg::HeldMax; m++) begin
                pend_bytes_reg[m] <= pend_bytes_next[m];
            end
        end
    end

    // A held sequence is always shorter than its lead announces.
    a_held_short: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_count_reg != 2'd0 |->
            u8vd_pkg::lead_len(pend_bytes_reg[0]) > {1'b0, pend_count_reg})
        else $error("held sequence is not a valid incomplete prefix");

endmodule

>>> hw/rtl/u8vd_queue.sv
// Short queue of token bundles between the front and back parts.
module u8vd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  u8vd_pkg::bundle_t push_data,
    output logic              full,
    input  logic              pop,
    output u8vd_pkg::bundle_t pop_data,
    output logic              empty
);

    u8vd_pkg::bundle_t mem_reg [u8vd_pkg::QueueDepth];
    logic [u8vd_pkg::QueueIdxW-1:0] wr_ptr_reg;
    logic [u8vd_pkg::QueueIdxW-1:0] rd_ptr_reg;
    logic [u8vd_pkg::QueueCntW-1:0] count_reg;
    logic [u8vd_pkg::QueueCntW-1:0] count_next;

    assign full     = count_reg == u8vd_pkg::QueueCntW'(u8vd_pkg::QueueDepth);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + u8vd_pkg::QueueCntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - u8vd_pkg::QueueCntW'(1);
        end
    end

    // Storage is written at the write pointer only.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // The queue never overflows nor underflows.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= u8vd_pkg::QueueCntW'(u8vd_pkg::QueueDepth) && !(pop && empty))
        else $error("queue occupancy out of range");

endmodule

>>> hw/rtl/u8vd_back.sv
// Back part: takes bundles from the queue, splits surrogates and drives the result stream.
module u8vd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              q_empty,
    input  u8vd_pkg::bundle_t q_data,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    logic              utf16_reg;
    u8vd_pkg::bundle_t cur_reg;
    logic              cur_valid_reg;
    logic [1:0]        idx_reg;
    logic              half_reg;
    logic              out_valid_reg;
    logic [20:0]       out_code_reg;
    logic              out_raw_reg;
    logic              out_last_reg;

    u8vd_pkg::tok_t tok_w;
    logic [19:0]    offs_w;
    logic [20:0]    unit_w;
    logic           split_w;
    logic           tok_end_w;
    logic           last_w;
    logic           load_w;
    logic           take_w;

    // Current token and its result unit.
    assign tok_w   = cur_reg.tok[idx_reg];
    assign split_w = utf16_reg && !tok_w.raw && (tok_w.code >= u8vd_pkg::SuppBase);
    assign offs_w  = 20'(tok_w.code - u8vd_pkg::SuppBase);

    always_comb begin
        if (!split_w) begin
            unit_w = tok_w.code;
        end else if (half_reg) begin
            unit_w = {5'd0, u8vd_pkg::LowSurrBase + {6'd0, offs_w[9:0] & u8vd_pkg::TenBitMask}};
        end else begin
            unit_w = {5'd0, u8vd_pkg::HighSurrBase + {6'd0, offs_w[19:10]}};
        end
    end

    assign tok_end_w = !split_w || half_reg;
    assign last_w    = tok_end_w && ({1'b0, idx_reg} == cur_reg.cnt - 3'd1);
    assign load_w    = cur_valid_reg && (!out_valid_reg || m_tready);
    assign take_w    = !q_empty && (!cur_valid_reg || (load_w && last_w));
    assign q_pop     = take_w;

    // Mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utf16_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            utf16_reg <= cfg_wr_data;
        end
    end

    // Walk through the current bundle one result per transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            half_reg      <= 1'b0;
        end else begin
            if (take_w) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
                half_reg      <= 1'b0;
            end else if (load_w) begin
                if (last_w) begin
                    cur_valid_reg <= 1'b0;
                    idx_reg       <= 2'd0;
                    half_reg      <= 1'b0;
                end else if (tok_end_w) begin
                    idx_reg  <= idx_reg + 2'd1;
                    half_reg <= 1'b0;
                end else begin
                    half_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_w) begin
            cur_reg <= q_data;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_w) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_w) begin
            out_code_reg <= unit_w;
            out_raw_reg  <= tok_w.raw;
            out_last_reg <= last_w;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_code_reg};
    assign m_tuser  = out_raw_reg;
    assign m_tlast  = out_last_reg;

    // The token index stays inside a non-empty bundle.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (cur_reg.cnt != 3'd0 && {1'b0, idx_reg} < cur_reg.cnt))
        else $error("token index outside current bundle");

    // The low surrogate half is only ever pending on a decoded supplementary point.
    a_half_split: assert property (@(posedge aclk) disable iff (!aresetn)
        half_reg |-> (cur_valid_reg && split_w))
        else $error("low surrogate pending without a split token");

endmodule

>>> hw/rtl/utf8_validating_decoder.sv
// Top level of the UTF-8 validating decoder.
// The decoder takes one text byte per cycle on the s_ stream and gives one code unit per
// cycle on the m_ stream, each while the queue or m_tready does not stall it. A byte is
// resolved in the cycle it is accepted, and the results it causes enter a two-entry bundle
// queue at that edge; the first of them then passes the current-bundle register and the
// output register before it is presented on the m_ stream. The back part sends one result
// per cycle unless m_tready holds it, and the input stalls only once both queue entries
// are waiting. A valid sequence gives its code point, or with utf16_out set a surrogate pair
// for points above 0xFFFF; an invalid sequence gives its lead byte with m_tuser set and the
// bytes after it are scanned again. m_tlast marks the last result caused by one input byte.
module utf8_validating_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // utf16_out
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] text_byte
    input  logic        s_tlast,       // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [20:0] code_unit, [23:21] zero
    output logic        m_tuser,       // raw_byte
    output logic        m_tlast        // run_last
);

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    u8vd_pkg::bundle_t push_data;
    u8vd_pkg::bundle_t pop_data;

    // Sequence resolution.
    u8vd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    // Bundle queue.
    u8vd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // Result serialisation.
    u8vd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .q_data      (pop_data),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

>>> tb/utf8_validating_decoder_tb.sv
// Self-checking testbench for the UTF-8 validating decoder, with its own decode predictor.
module utf8_validating_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CyclePeriod = 20;
    localparam int CycleLimit  = 200000;
    localparam int SettleWait  = 8;

    // Kinds of damage applied to an otherwise well-formed sequence.
    typedef enum int {
        FlawNone,
        FlawCut,
        FlawSpoil
    } flaw_t;

    // One text byte waiting to be sent.
    typedef struct packed {
        logic [7:0] text;
        logic       eot;
    } text_item_t;

    // One code unit the decoder should produce.
    typedef struct packed {
        logic [20:0] code;
        logic        raw;
        logic        last;
    } code_unit_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    text_item_t pending_text[$];
    code_unit_t decoded_units[$];

    // Predictor state: the bytes of a started sequence and the output mode.
    logic [7:0] held_bytes [3];
    int         held_count = 0;
    logic       utf16_mode = 1'b0;

    text_item_t next_item;
    code_unit_t seen_unit;
    int         burst_left  = 1;
    int         gap_left    = 0;
    int         ready_cycle = 0;
    int         cycle_count = 0;
    logic       failed      = 1'b0;

    // Edge cases sent first: limits of ASCII, stray and forbidden leads, the shortest two-byte form,
    // an over-long form, a surrogate, a point above the limit, a supplementary point,
    // a missing continuation and a sequence cut off by the end of the text.
    logic [7:0] opening_text [25] = '{
        8'h00, 8'h7F,
        8'h80, 8'hC0, 8'hFF,
        8'hC2, 8'h80,
        8'hE0, 8'h80, 8'h80,
        8'hED, 8'hA0, 8'h80,
        8'hF4, 8'h90, 8'h80, 8'h80,
        8'hF0, 8'h9F, 8'h98, 8'h80,
        8'hC3, 8'h41,
        8'hE2, 8'h82
    };

    utf8_validating_decoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // Clock generation.
    initial begin
        forever begin
            #(CyclePeriod / 2) aclk = ~aclk;
        end
    end

    // Length announced by a byte in lead position; zero when it cannot lead.
    function automatic int seq_length(input logic [7:0] b);
        if (b < 8'h80) return 1;
        if (b >= 8'hC2 && b <= 8'hDF) return 2;
        if (b >= 8'hE0 && b <= 8'hEF) return 3;
        if (b >= 8'hF0 && b <= 8'hF4) return 4;
        return 0;
    endfunction

    function automatic void note_unit(input logic [20:0] code, input logic raw);
        code_unit_t unit_val;
        unit_val = '{code: code, raw: raw, last: 1'b0};
        decoded_units.insert(decoded_units.size(), unit_val);
    endfunction

    // Resolves everything one accepted byte makes decidable and queues the code units.
    function automatic void decode_byte(input logic [7:0] b, input logic eot);
        logic [7:0]  work [4];
        int          k, i, j, len, avail, lim, n;
        logic        bad;
        logic [20:0] cp, shortest, offset;
        k = 0;
        n = 0;
        for (j = 0; j < held_count; j++) begin
            work[k] = held_bytes[j];
            k++;
        end
        work[k] = b;
        k++;
        held_count = 0;
        i = 0;
        while (i < k) begin
            len = seq_length(work[i]);
            avail = k - i;
            if (len == 0) begin
                note_unit({13'd0, work[i]}, 1'b1);
                n++;
                i++;
            end else if (len == 1) begin
                note_unit({13'd0, work[i]}, 1'b0);
                n++;
                i++;
            end else begin
                // A non-continuation byte inside the sequence condemns the lead at once.
                lim = (avail < len) ? avail : len;
                bad = 1'b0;
                for (j = 1; j < lim; j++) begin
                    if (work[i + j][7:6] != 2'b10) bad = 1'b1;
                end
                if (bad || (avail < len && eot)) begin
                    note_unit({13'd0, work[i]}, 1'b1);
                    n++;
                    i++;
                end else if (avail < len) begin
                    for (j = 0; j < avail; j++) held_bytes[j] = work[i + j];
                    held_count = avail;
                    i = k;
                end else begin
                    cp = 21'(work[i] & (8'h7F >> len));
                    for (j = 1; j < len; j++) cp = (cp << 6) | 21'(work[i + j][5:0]);
                    shortest = (len == 2) ? 21'h80 : (len == 3) ? 21'h800 : 21'h10000;
                    if (cp < shortest || cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF))
                    begin
                        note_unit({13'd0, work[i]}, 1'b1);
                        n++;
                        i++;
                    end else begin
                        if (utf16_mode && cp > 21'hFFFF) begin
                            offset = cp - 21'h10000;
                            note_unit(21'hD800 + 21'(offset[20:10]), 1'b0);
                            note_unit(21'hDC00 + 21'(offset[9:0]), 1'b0);
                            n += 2;
                        end else begin
                            note_unit(cp, 1'b0);
                            n++;
                        end
                        i += len;
                    end
                end
            end
        end
        if (n > 0) decoded_units[decoded_units.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_text_byte(input logic [7:0] b, input logic eot);
        text_item_t item_val;
        item_val = '{text: b, eot: eot};
        pending_text.insert(pending_text.size(), item_val);
    endfunction

    // Encodes a value in the given length, valid or not, and optionally damages it.
    function automatic void push_encoded(input logic [20:0] cp, input int len, input flaw_t flaw);
        logic [7:0] seq_bytes [4];
        int         keep, j;
        case (len)
            1: begin
                seq_bytes[0] = {1'b0, cp[6:0]};
            end
            2: begin
                seq_bytes[0] = {3'b110, cp[10:6]};
                seq_bytes[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq_bytes[0] = {4'b1110, cp[15:12]};
                seq_bytes[1] = {2'b10, cp[11:6]};
                seq_bytes[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq_bytes[0] = {5'b11110, cp[20:18]};
                seq_bytes[1] = {2'b10, cp[17:12]};
                seq_bytes[2] = {2'b10, cp[11:6]};
                seq_bytes[3] = {2'b10, cp[5:0]};
            end
        endcase
        keep = len;
        if (len > 1 && flaw == FlawCut) keep = $urandom_range(1, len - 1);
        if (len > 1 && flaw == FlawSpoil) seq_bytes[$urandom_range(1, len - 1)] = 8'($urandom);
        for (j = 0; j < keep; j++) add_text_byte(seq_bytes[j], $urandom_range(0, 15) == 0);
    endfunction

    // A legal code point for the given length, with a bias towards the range limits.
    function automatic logic [20:0] pick_point(input int len);
        logic       at_limit;
        logic [20:0] cp;
        at_limit = ($urandom_range(0, 3) == 0);
        case (len)
            1: cp = at_limit ? ($urandom_range(0, 1) ? 21'h7F : 21'h00) : 21'($urandom_range(0, 'h7F));
            2: cp = at_limit ? ($urandom_range(0, 1) ? 21'h7FF : 21'h80)
                             : 21'($urandom_range('h80, 'h7FF));
            3: begin
                if (at_limit) begin
                    case ($urandom_range(0, 3))
                        0: cp = 21'h800;
                        1: cp = 21'hD7FF;
                        2: cp = 21'hE000;
                        default: cp = 21'hFFFF;
                    endcase
                end else begin
                    cp = 21'($urandom_range('h800, 'hFFFF));
                    if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
                end
            end
            default: cp = at_limit ? ($urandom_range(0, 1) ? 21'h10FFFF : 21'h10000)
                                   : 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    // One random piece of text: half well-formed, some damaged, some ill-formed, some noise.
    function automatic void add_random_sequence();
        int          sel, len;
        logic [20:0] shortest;
        sel = $urandom_range(0, 99);
        len = $urandom_range(1, 4);
        if (sel < 10) begin
            add_text_byte(8'($urandom), $urandom_range(0, 15) == 0);
        end else if (sel < 60) begin
            push_encoded(pick_point(len), len, FlawNone);
        end else if (sel < 80) begin
            push_encoded(pick_point(len), len, $urandom_range(0, 1) ? FlawCut : FlawSpoil);
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    // Over-long form of a value that fits a shorter sequence.
                    len = $urandom_range(2, 4);
                    shortest = (len == 2) ? 21'h80 : (len == 3) ? 21'h800 : 21'h10000;
                    push_encoded(21'($urandom_range(0, shortest - 1)), len, FlawNone);
                end
                1: push_encoded(21'($urandom_range('hD800, 'hDFFF)), 3, FlawNone);
                default: push_encoded(21'($urandom_range('h110000, 'h1FFFFF)), 4, FlawNone);
            endcase
        end
    endfunction

    // Waits until every byte is accepted and every code unit has arrived, then lets it settle.
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (pending_text.size() != 0 || s_tvalid || decoded_units.size() != 0);
        repeat (SettleWait) @(negedge aclk);
    endtask

    task automatic write_mode(input logic value);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        utf16_mode = value;
    endtask

    task automatic fill_random(input int count);
        while (pending_text.size() < count) add_random_sequence();
    endtask

    // Reset, then phases of text under alternating output modes.
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        write_mode(1'b1);
        for (int j = 0; j < 25; j++) add_text_byte(opening_text[j], j == 24);
        write_mode(1'b0);
        fill_random(85);
        write_mode(1'b1);
        fill_random(85);
        write_mode(1'b0);
        fill_random(85);
        wait_idle();
        if (!failed) begin
            $display("PASS utf8_validating_decoder");
        end else begin
            $display("FAIL utf8_validating_decoder");
        end
        $finish;
    end

    // Sender: predicts on each accepted transaction and presents bytes in bursts with gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (gap_left == 0 && pending_text.size() != 0) begin
                    next_item = pending_text.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.text;
                    s_tlast  <= next_item.eot;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                    if (gap_left != 0) gap_left--;
                end
            end
        end
    end

    // Receiver: ready pattern rotates between full rate and several stall styles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            ready_cycle++;
            case ((ready_cycle >> 6) & 3)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ((ready_cycle & 3) == 0);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Checker: each output transaction against the oldest predicted code unit.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_units.size() == 0) begin
                $error("unexpected code unit 0x%06h raw %0b last %0b",
                       m_tdata[20:0], m_tuser, m_tlast);
                failed <= 1'b1;
            end else begin
                seen_unit = decoded_units.pop_front();
                if (m_tdata[20:0] !== seen_unit.code) begin
                    $error("code_unit: expected 0x%06h, got 0x%06h", seen_unit.code, m_tdata[20:0]);
                    failed <= 1'b1;
                end
                if (m_tuser !== seen_unit.raw) begin
                    $error("raw_byte: expected %0b, got %0b", seen_unit.raw, m_tuser);
                    failed <= 1'b1;
                end
                if (m_tlast !== seen_unit.last) begin
                    $error("run_last: expected %0b, got %0b", seen_unit.last, m_tlast);
                    failed <= 1'b1;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAIL utf8_validating_decoder");
            $finish;
        end
    end

endmodule

>>> files.f
hw/rtl/u8vd_pkg.sv
hw/rtl/u8vd_front.sv
hw/rtl/u8vd_queue.sv
hw/rtl/u8vd_back.sv
hw/rtl/utf8_validating_decoder.sv
tb/utf8_validating_decoder_tb.sv
